/* rtl/eto_pkg.sv */
// Shared types, constants and the sine table function of the enveloped tone oscillator.
package eto_pkg;

  localparam int PhaseBits  = 32;
  localparam int LengthBits = 20;
  localparam int SampleBits = 16;
  localparam int EnvBits    = 17;
  localparam int MagBits    = 16;

  localparam logic [MagBits-1:0] FullScale = 16'd32767;
  localparam logic [30:0]        SawScale  = 31'd32767;
  localparam logic [30:0]        TriScale  = 31'd2071529740;

  localparam longint unsigned Q30One = 64'd1 << 30;
  localparam longint unsigned SinCoef [5] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272
  };

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_e;

  typedef struct packed {
    logic                  start_note;
    logic [PhaseBits-1:0]  phase_step;
    logic [LengthBits-1:0] note_length;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         note_active;
    logic                         last_sample;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic est;
    logic chk;
    logic fix;
    logic mul1;
    logic mul2;
    logic emit;
  } eto_cmd_t;

  typedef struct packed {
    logic out_free;
  } eto_sts_t;

  function automatic logic signed [SampleBits-1:0] sine_entry(input longint unsigned k,
                                                              input int unsigned aw);
    longint unsigned q4;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned y;
    longint unsigned m;
    q4   = k << 2;
    quad = q4 >> aw;
    r    = q4 & ((64'd1 << aw) - 64'd1);
    t    = (r << 30) >> aw;
    x    = quad[0] ? (Q30One - t) : t;
    x2   = (x * x) >> 30;
    p    = SinCoef[4];
    for (int n = 3; n >= 0; n--) begin
      p = SinCoef[n] - ((x2 * p) >> 30);
    end
    y = (x * p) >> 30;
    m = (y * 64'd32767 + (64'd1 << 29)) >> 30;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return quad[1] ? -SampleBits'(m) : SampleBits'(m);
  endfunction

endpackage

/* rtl/eto_stream_if.sv */
// Valid/ready channel carrying one payload item per transfer.
interface eto_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/enveloped_tone_oscillator.sv */
// Enveloped tone oscillator: one enveloped waveform sample per sample-tick transfer.
// Each input transfer is one sample tick and yields exactly one output transfer. An item
// passes through eight steps: one accept step, one prepare step (envelope ramps,
// sine table read, phase and index advance), three envelope steps (reciprocal-multiply
// estimate, multiply back, compare and correct), two multiplier stages and one output step.
// The result is written to the output register in the output step, and the block takes no
// new tick while an item is in flight. The next tick is taken in the cycle after the result
// is written to the output register, so a slow sink stalls the block only when the register
// is still full at the output step.
// SineTableDepth must be a power of two. Write the waveform register only while idle.
module enveloped_tone_oscillator
  import eto_pkg::*;
#(
  parameter int RampSamples    = 1000,
  parameter int SineTableDepth = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  eto_stream_if.sink   cfg_if,
  eto_stream_if.sink   in_if,
  eto_stream_if.source out_if
);

  eto_cmd_t  cmd;
  eto_sts_t  sts;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

  eto_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eto_dp #(
    .RampSamples    (RampSamples),
    .SineTableDepth (SineTableDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_if.valid),
    .cfg_wave_i  (wave_e'(cfg_if.data)),
    .in_data_i   (in_item_t'(in_if.data)),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_data)
  );

endmodule

/* rtl/eto_ctrl.sv */
// Sequencer of the oscillator: prepare, envelope divide, scale and output steps.
module eto_ctrl
  import eto_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  eto_sts_t sts_i,
  output eto_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_EST  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_MUL1 = 3'd5;
  localparam logic [2:0] S_MUL2 = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_EST;
      end
      S_EST: begin
        cmd_o.est = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result emitted while output register is occupied");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command in a cycle");

  a_load_then_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_PREP) && !in_ready_o)
    else $error("accepted transfer not followed by prepare step");

endmodule

/* rtl/eto_dp.sv */
// Datapath of the oscillator: note state, sine table, envelope divider, scaler, output register.
module eto_dp
  import eto_pkg::*;
#(
  parameter int RampSamples    = 1000,
  parameter int SineTableDepth = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  wave_e     cfg_wave_i,
  input  in_item_t  in_data_i,
  input  eto_cmd_t  cmd_i,
  output eto_sts_t  sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int RampBits = $clog2(RampSamples + 1);
  localparam int ProdBits = 2 * RampBits;
  localparam int RecBits  = EnvBits + 2;
  localparam int EstBits  = ProdBits + RecBits;
  localparam int BackBits = ProdBits + EnvBits;
  localparam int SineAw   = $clog2(SineTableDepth);
  localparam int P1Bits   = EnvBits + MagBits;
  localparam int P2Bits   = P1Bits + 31;
  localparam logic [LengthBits-1:0] RampLen = LengthBits'(RampSamples);
  localparam logic [ProdBits-1:0]   Den     =
    ProdBits'(longint'(RampSamples) * longint'(RampSamples));
  localparam logic [RecBits-1:0]    Recip   =
    RecBits'((64'd1 << (ProdBits + EnvBits - 1)) / 64'(Den));

  logic signed [SampleBits-1:0] sine_lut [SineTableDepth];

  for (genvar g = 0; g < SineTableDepth; g++) begin : g_lut
    assign sine_lut[g] = sine_entry(64'(g), SineAw);
  end

  wave_e                 wave_q;
  logic [PhaseBits-1:0]  step_q, phase_q;
  logic [LengthBits-1:0] len_q, idx_q;
  logic [ProdBits-1:0]   prod_q;
  logic [EnvBits-1:0]    quo_q;
  logic [BackBits-1:0]   back_q;
  logic [MagBits-1:0]    mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic                  zero_q, active_q, last_q;
  logic [P1Bits-1:0]     p1_q;
  logic [P2Bits-1:0]     p2_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic                         active, last;
  logic [LengthBits-1:0]        remain;
  logic [RampBits-1:0]          ramp_a, ramp_b;
  logic [15:0]                  u;
  logic [EnvBits-1:0]           u2;
  logic [EnvBits:0]             u2_wrap;
  logic signed [SampleBits-1:0] s;
  logic [EstBits-1:0]           est_prod;
  logic [BackBits-1:0]          num;
  logic [BackBits-1:0]          slack;
  logic [30:0]                  kmul;
  logic [MagBits-1:0]           res_mag;
  logic signed [SampleBits-1:0] res;

  assign active = (idx_q < len_q);
  assign last   = active && ((LengthBits + 1)'(idx_q) + 1'b1 == {1'b0, len_q});
  assign remain = len_q - idx_q;
  assign ramp_a = (idx_q < RampLen) ? RampBits'(idx_q) : RampBits'(RampSamples);
  assign ramp_b = (remain < RampLen) ? RampBits'(remain) : RampBits'(RampSamples);

  assign u       = phase_q[PhaseBits-1 -: 16];
  assign u2      = {u, 1'b0};
  assign u2_wrap = 18'd131072 - {1'b0, u2};
  assign s       = sine_lut[phase_q[PhaseBits-1 -: SineAw]];

  always_comb begin
    mag_d = '0;
    neg_d = 1'b0;
    case (wave_q)
      WAVE_SINE: begin
        neg_d = s[SampleBits-1];
        mag_d = s[SampleBits-1] ? MagBits'(-s) : MagBits'(s);
      end
      WAVE_SQUARE: begin
        neg_d = s[SampleBits-1];
        mag_d = FullScale;
      end
      WAVE_SAW: begin
        neg_d = !u[15];
        mag_d = u[15] ? {1'b0, u[14:0]} : (16'h8000 - u);
      end
      WAVE_TRI: begin
        if (u < 16'd16384) begin
          neg_d = 1'b0;
          mag_d = MagBits'(u2);
        end else if (u < 16'd32768) begin
          neg_d = 1'b0;
          mag_d = MagBits'(17'd65536 - u2);
        end else if (u < 16'd49152) begin
          neg_d = 1'b1;
          mag_d = MagBits'(u2 - 17'd65536);
        end else begin
          neg_d = 1'b1;
          mag_d = MagBits'(u2_wrap);
        end
      end
      default: begin
        mag_d = '0;
        neg_d = 1'b0;
      end
    endcase
  end

  // estimate is the true quotient or one below it
  assign est_prod = EstBits'(prod_q) * EstBits'(Recip);
  assign num      = BackBits'(prod_q) << (EnvBits - 1);
  assign slack    = num - back_q;

  always_comb begin
    case (wave_q)
      WAVE_SAW: kmul = SawScale;
      WAVE_TRI: kmul = TriScale;
      default:  kmul = 31'd1;
    endcase
  end

  always_comb begin
    case (wave_q)
      WAVE_SAW: res_mag = p2_q[31 +: MagBits];
      WAVE_TRI: res_mag = p2_q[47 +: MagBits];
      default:  res_mag = p2_q[16 +: MagBits];
    endcase
  end

  assign res = zero_q ? '0 : (neg_q ? -$signed(res_mag) : $signed(res_mag));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q  <= WAVE_SINE;
      step_q  <= '0;
      len_q   <= '0;
      phase_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        wave_q <= cfg_wave_i;
      end
      if (cmd_i.load && in_data_i.start_note) begin
        step_q  <= in_data_i.phase_step;
        len_q   <= in_data_i.note_length;
        phase_q <= '0;
        idx_q   <= '0;
      end else if (cmd_i.prep && active) begin
        phase_q <= phase_q + step_q;
        idx_q   <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      prod_q   <= ProdBits'(ramp_a) * ProdBits'(ramp_b);
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      zero_q   <= !active || (step_q == '0);
      active_q <= active;
      last_q   <= last;
    end
    if (cmd_i.est) begin
      quo_q <= est_prod[ProdBits +: EnvBits];
    end
    if (cmd_i.chk) begin
      back_q <= BackBits'(quo_q) * BackBits'(Den);
    end
    if (cmd_i.fix && (slack >= BackBits'(Den))) begin
      quo_q <= quo_q + 1'b1;
    end
    if (cmd_i.mul1) begin
      p1_q <= P1Bits'(quo_q) * P1Bits'(mag_q);
    end
    if (cmd_i.mul2) begin
      p2_q <= P2Bits'(p1_q) * P2Bits'(kmul);
    end
    if (cmd_i.emit) begin
      out_q.sample      <= res;
      out_q.note_active <= active_q;
      out_q.last_sample <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_idle_note_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep && !active |=> $stable(idx_q) && $stable(phase_q))
    else $error("phase or index moved after the note ended");

  a_active_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep && active |=> idx_q == $past(idx_q) + 1'b1)
    else $error("index did not advance on an active sample");

  a_silent_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && zero_q |=> out_q.sample == '0)
    else $error("nonzero sample during rest or after note end");

endmodule

/* tb/sv/enveloped_tone_oscillator_tb.sv */
// Testbench for the enveloped tone oscillator: random sample ticks checked against a tone predictor.
module enveloped_tone_oscillator_tb
  import eto_pkg::*;
();

  localparam longint unsigned RAMP = 1000;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam longint unsigned POLY0 = 64'd1686629713;
  localparam longint unsigned POLY1 = 64'd693598668;
  localparam longint unsigned POLY2 = 64'd85569306;
  localparam longint unsigned POLY3 = 64'd5026995;
  localparam longint unsigned POLY4 = 64'd172272;
  localparam int MAX_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_TICKS = 270;
  localparam int MIX_PHASES = 8;
  localparam int MIX_TICKS = 90;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_TOGGLE
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  eto_stream_if #(.payload_t(wave_e))     cfg_ch ();
  eto_stream_if #(.payload_t(in_item_t))  tick_ch ();
  eto_stream_if #(.payload_t(out_item_t)) sample_ch ();

  enveloped_tone_oscillator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch),
    .in_if  (tick_ch),
    .out_if (sample_ch)
  );

  in_item_t  tick_queue[$];
  out_item_t expected_samples[$];

  int ticks_queued = 0;
  int ticks_sent = 0;
  int samples_seen = 0;
  int n_errors = 0;
  int cycle_count = 0;
  int note_left = 0;

  int burst_left = 0;
  int gap_left = 0;
  int sink_mode_left = 0;
  int holdoff_left = 0;
  int holdoffs_done = 0;
  sink_mode_e sink_mode = SINK_OPEN;

  logic [31:0] phase_acc = '0;
  logic [31:0] step_reg = '0;
  logic [19:0] len_reg = '0;
  logic [19:0] idx_reg = '0;
  wave_e wave_sel = WAVE_SINE;

  function automatic int sine_level(logic [31:0] ph);
    longint unsigned k;
    longint unsigned quad;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned y;
    longint unsigned m;
    k = longint'(ph[31:24]);
    quad = k >> 6;
    x = ((k << 2) & 64'd255) << 22;
    if (quad[0]) begin
      x = Q30 - x;
    end
    x2 = (x * x) >> 30;
    p = POLY4;
    p = POLY3 - ((x2 * p) >> 30);
    p = POLY2 - ((x2 * p) >> 30);
    p = POLY1 - ((x2 * p) >> 30);
    p = POLY0 - ((x2 * p) >> 30);
    y = (x * p) >> 30;
    m = (y * 64'd32767 + (64'd1 << 29)) >> 30;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return quad[1] ? -int'(m) : int'(m);
  endfunction

  function automatic out_item_t next_sample(in_item_t tick);
    out_item_t res;
    longint unsigned a;
    longint unsigned b;
    longint env;
    longint u;
    longint t;
    longint v;
    longint d;
    if (tick.start_note) begin
      step_reg = tick.phase_step;
      len_reg = tick.note_length;
      phase_acc = '0;
      idx_reg = '0;
    end
    res = '0;
    res.note_active = (idx_reg < len_reg);
    res.last_sample = res.note_active && (idx_reg + 20'd1 == len_reg);
    if (res.note_active && step_reg != '0) begin
      a = idx_reg;
      if (a > RAMP) begin
        a = RAMP;
      end
      b = len_reg - idx_reg;
      if (b > RAMP) begin
        b = RAMP;
      end
      env = longint'((a * b * 64'd65536) / (RAMP * RAMP));
      u = longint'(phase_acc[31:16]);
      case (wave_sel)
        WAVE_SINE: begin
          v = sine_level(phase_acc);
          d = 1;
        end
        WAVE_SAW: begin
          v = longint'(32767) * (u - 32768);
          d = 32768;
        end
        WAVE_SQUARE: begin
          v = (sine_level(phase_acc) >= 0) ? 32767 : -32767;
          d = 1;
        end
        default: begin
          if (u < 16384) begin
            t = 2 * u;
          end else if (u < 49152) begin
            t = 65536 - 2 * u;
          end else begin
            t = 2 * u - 131072;
          end
          v = longint'(32767) * 63220 * t;
          d = longint'(65536) * 32768;
        end
      endcase
      res.sample = 16'((env * v) / (longint'(65536) * d));
    end
    if (res.note_active) begin
      phase_acc = phase_acc + step_reg;
      idx_reg = idx_reg + 20'd1;
    end
    return res;
  endfunction

  function automatic void queue_tick(logic start, logic [31:0] step, logic [19:0] len);
    in_item_t item;
    item = in_item_t'{start_note: start, phase_step: step, note_length: len};
    tick_queue = {tick_queue, item};
    ticks_queued++;
    if (start) begin
      note_left = len;
    end
    if (note_left > 0) begin
      note_left--;
    end
  endfunction

  function automatic void queue_random_tick();
    logic        start;
    logic [31:0] step;
    logic [19:0] len;
    step = $urandom();
    len = 20'($urandom());
    start = (note_left == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 24) == 0);
    if (start) begin
      case ($urandom_range(0, 9))
        0: step = '0;
        1: step = 32'h8000_0000;
        2: step = 32'($urandom_range(1, 65535));
        default: ;
      endcase
      case ($urandom_range(0, 19))
        0: len = '0;
        1: len = 20'hF_FFFF;
        2: len = 20'($urandom_range(100, 400));
        default: len = 20'($urandom_range(1, 40));
      endcase
    end
    queue_tick(start, step, len);
  endfunction

  task automatic write_wave(wave_e w);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    @(posedge clk_i);
    while (!cfg_ch.ready) begin
      @(posedge clk_i);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ticks_sent != ticks_queued || expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && (!tick_ch.valid || tick_ch.ready)) begin
      if (gap_left > 0 || tick_queue.size() == 0) begin
        tick_ch.valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end
      end else begin
        tick_ch.valid <= 1'b1;
        tick_ch.data <= tick_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      sample_ch.ready <= 1'b0;
    end else begin
      if (sink_mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        sink_mode_left = $urandom_range(8, 120);
      end else begin
        sink_mode_left = sink_mode_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:   sample_ch.ready <= 1'b1;
        SINK_COIN:   sample_ch.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: sample_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     sample_ch.ready <= ~sample_ch.ready;
      endcase
      // hold off the sink for a long stretch while ticks keep coming
      if (holdoffs_done < 2 && samples_seen >= 400 + 900 * holdoffs_done) begin
        holdoff_left = 300;
        holdoffs_done = holdoffs_done + 1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        wave_sel = cfg_ch.data;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        samples_seen <= samples_seen + 1;
        got = sample_ch.data;
        if (expected_samples.size() == 0) begin
          n_errors++;
          $error("sample transfer with no tick pending: sample %0d", got.sample);
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample) begin
            n_errors++;
            $error("sample: expected %0d, got %0d", want.sample, got.sample);
          end
          if (got.note_active !== want.note_active) begin
            n_errors++;
            $error("note_active: expected %0b, got %0b", want.note_active, got.note_active);
          end
          if (got.last_sample !== want.last_sample) begin
            n_errors++;
            $error("last_sample: expected %0b, got %0b", want.last_sample, got.last_sample);
          end
        end
      end
      if (tick_ch.valid && tick_ch.ready) begin
        expected_samples = {expected_samples, next_sample(tick_ch.data)};
        ticks_sent <= ticks_sent + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = WAVE_SINE;
    tick_ch.valid = 1'b0;
    tick_ch.data = '0;
    sample_ch.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_wave(WAVE_SINE);
    queue_tick(1'b0, 32'hFFFF_FFFF, 20'hF_FFFF);
    queue_tick(1'b1, 32'h1234_5678, 20'h0_0000);
    queue_tick(1'b0, 32'h0000_0000, 20'h0_0000);
    queue_tick(1'b1, 32'h8000_0000, 20'h0_0001);
    queue_tick(1'b0, 32'hA5A5_A5A5, 20'h5_A5A5);
    queue_tick(1'b1, 32'h0000_0000, 20'h0_0003);
    repeat (3) queue_tick(1'b0, 32'h0, 20'h0);
    queue_tick(1'b1, 32'hFFFF_FFFF, 20'h0_0005);
    repeat (5) queue_tick(1'b0, 32'h5A5A_5A5A, 20'hA_5A5A);
    queue_tick(1'b1, 32'h0100_0000, 20'hF_FFFF);
    repeat (2) queue_tick(1'b0, 32'h0, 20'h0);
    queue_tick(1'b1, 32'h4000_0000, 20'h0_0004);
    queue_tick(1'b0, 32'h0, 20'h0);
    queue_tick(1'b1, 32'h2000_0000, 20'h0_0002);
    repeat (2) queue_tick(1'b0, 32'h0, 20'h0);
    wait_drained();

    // one long note spanning four waveforms, reaching the full envelope
    queue_tick(1'b1, 32'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF)),
               20'($urandom_range(2000, 2300)));
    for (int w = 1; w <= 4; w++) begin
      wait_drained();
      write_wave(wave_e'(w % 4));
      repeat (LONG_TICKS) queue_tick(1'b0, $urandom(), 20'($urandom()));
    end
    wait_drained();

    for (int ph = 0; ph < MIX_PHASES; ph++) begin
      write_wave((ph < 4) ? wave_e'(ph) : wave_e'($urandom_range(0, 3)));
      repeat (MIX_TICKS) queue_random_tick();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
